FILE: src/mrwa_pkg.sv
// Package: shared constants and types for the multi-rate window averager.
package mrwa_pkg;

  localparam int unsigned FieldW = 24;
  localparam int unsigned CountW = 6;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned LevelW = 2;

  localparam logic [LevelW-1:0] LVL_SAMPLE = 2'd0;
  localparam logic [LevelW-1:0] LVL_MINUTE = 2'd1;
  localparam logic [LevelW-1:0] LVL_HOUR   = 2'd2;

  localparam logic CFG_SPM = 1'b0;
  localparam logic CFG_MPH = 1'b1;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Result of one item, held until the output transfer.
  typedef struct packed {
    logic              minute_pushed;
    logic [FieldW-1:0] minute_mean;
    logic              hour_pushed;
    logic [FieldW-1:0] hour_mean;
    logic [FieldW-1:0] read_value;
    logic              read_hit;
    logic [CountW-1:0] level_fill;
  } result_t;

endpackage

FILE: src/mrwa_ram.sv
// Generic single-port-write RAM with registered read.
module mrwa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 960
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/mrwa_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module mrwa_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,    // signed
  input  logic [DEN_W-1:0] den,    // unsigned, nonzero
  output logic             busy,
  output logic [NUM_W-1:0] quot    // signed
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (start) begin
      neg_nxt  = num[NUM_W-1];
      q_nxt    = num[NUM_W-1] ? (~num + 1'b1) : num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift one dividend bit in, subtract when it fits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        if (neg_r) begin
          q_nxt = ~{q_r[NUM_W-2:0], (trial >= {1'b0, den_r})} + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule

FILE: src/multi_rate_window_averager_core.sv
// Top level: per-channel sample, minute and hour windows with running means.
// A read passes through address, wait and capture states before its result; an add with no push only
// writes the sample. Each pushed mean is summed over its window, divided, then written to its ring;
// an add can push both the minute and the hour mean.
// One item at a time: the summing loop over one RAM read port and the bit-serial divider set the
// rate. Synchronous active-low reset clears per-channel counters; windows are read only below the fill.
module multi_rate_window_averager_core #(
  parameter int CHANNELS     = 16,
  parameter int SAMPLE_DEPTH = 60,
  parameter int MINUTE_DEPTH = 60,
  parameter int HOUR_DEPTH   = 24,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [5:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic [3:0]              in_channel,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic [1:0]              in_level,
  input  logic [5:0]              in_age_index,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_minute_pushed,
  output logic signed [SAMPLE_WIDTH-1:0] out_minute_mean,
  output logic                    out_hour_pushed,
  output logic signed [SAMPLE_WIDTH-1:0] out_hour_mean,
  output logic signed [SAMPLE_WIDTH-1:0] out_read_value,
  output logic                    out_read_hit,
  output logic [5:0]              out_level_fill
);
  import mrwa_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SD_W   = $clog2(SAMPLE_DEPTH);
  localparam int MD_W   = $clog2(MINUTE_DEPTH);
  localparam int HD_W   = $clog2(HOUR_DEPTH);
  localparam int SF_W   = $clog2(SAMPLE_DEPTH + 1);
  localparam int MF_W   = $clog2(MINUTE_DEPTH + 1);
  localparam int HF_W   = $clog2(HOUR_DEPTH + 1);
  localparam int SA_W   = $clog2(CHANNELS * SAMPLE_DEPTH);
  localparam int MA_W   = $clog2(CHANNELS * MINUTE_DEPTH);
  localparam int HA_W   = $clog2(CHANNELS * HOUR_DEPTH);
  localparam int SUM_W  = SAMPLE_WIDTH + 7;
  localparam int IDX_W  = 7;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDWAIT = 4'd1;
  localparam logic [3:0] S_RDOUT  = 4'd2;
  localparam logic [3:0] S_SWR    = 4'd3;
  localparam logic [3:0] S_MSUM   = 4'd4;
  localparam logic [3:0] S_MDIV   = 4'd5;
  localparam logic [3:0] S_MWR    = 4'd6;
  localparam logic [3:0] S_HSUM   = 4'd7;
  localparam logic [3:0] S_HDIV   = 4'd8;
  localparam logic [3:0] S_HWR    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_RDADDR = 4'd11;
  localparam logic [3:0] S_DIVGO  = 4'd12;

  logic [3:0] state_r, state_nxt;

  logic [5:0] spm_r, mph_r;

  // per-channel control state
  logic [SF_W-1:0] sfill_r [CHANNELS];
  logic [MF_W-1:0] mfill_r [CHANNELS];
  logic [HF_W-1:0] hfill_r [CHANNELS];
  logic [SD_W-1:0] shead_r [CHANNELS];
  logic [MD_W-1:0] mhead_r [CHANNELS];
  logic [HD_W-1:0] hhead_r [CHANNELS];
  logic [5:0]      stick_r [CHANNELS];
  logic [5:0]      mtick_r [CHANNELS];

  // latched item
  logic             mode_r;
  logic [3:0]       chan_r;
  logic [SAMPLE_WIDTH-1:0] samp_r;
  logic [1:0]       lvl_r;
  logic [5:0]       age_r;
  logic [CH_W-1:0]  ch;

  // loop state
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [IDX_W-1:0] cnt_r;
  logic             accum_r, accum_nxt;
  logic             div_go;
  logic [SAMPLE_WIDTH-1:0] mmean_r, hmean_r;
  result_t          res_r;

  // RAM ports
  logic                    s_we, m_we, h_we;
  logic [SA_W-1:0]         s_wa, s_ra;
  logic [MA_W-1:0]         m_wa, m_ra;
  logic [HA_W-1:0]         h_wa, h_ra;
  logic [SAMPLE_WIDTH-1:0] s_wd, m_wd, h_wd, s_rd, m_rd, h_rd;

  logic [SUM_W-1:0] div_q;
  logic             div_busy;

  assign ch = CH_W'(chan_r);

  mrwa_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(CHANNELS * SAMPLE_DEPTH)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  mrwa_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(CHANNELS * MINUTE_DEPTH)) u_mram (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  mrwa_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(CHANNELS * HOUR_DEPTH)) u_hram (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

  mrwa_div #(.NUM_W(SUM_W), .DEN_W(IDX_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(sum_r), .den(cnt_r),
    .busy(div_busy), .quot(div_q));

  // ring slot of age a: (head - fill + a) mod depth, all values below 2*depth
  function automatic logic [6:0] slot(input logic [6:0] head, input logic [6:0] fill,
                                      input logic [6:0] age, input logic [6:0] depth);
    logic [7:0] t;
    t = {1'b0, head} + {1'b0, depth} - {1'b0, fill} + {1'b0, age};
    if (t >= {1'b0, depth}) t = t - {1'b0, depth};
    if (t >= {1'b0, depth}) t = t - {1'b0, depth};
    return t[6:0];
  endfunction

  logic [6:0] s_slot, m_slot, h_slot;
  logic       ch_ok;
  logic [5:0] spm_eff, mph_eff;
  logic [5:0] stick_inc, mtick_inc;
  logic [6:0] sf_new, mf_new;

  assign ch_ok   = ({28'd0, chan_r} < 32'(CHANNELS));
  assign spm_eff = (spm_r == 6'd0) ? 6'd1 : spm_r;
  assign mph_eff = (mph_r == 6'd0) ? 6'd1 : mph_r;
  assign stick_inc = stick_r[ch] + 6'd1;
  assign mtick_inc = mtick_r[ch] + 6'd1;
  assign sf_new = 7'(sfill_r[ch]);
  assign mf_new = 7'(mfill_r[ch]);

  // read items hold the age address until the data is captured
  always_comb begin
    logic [6:0] a;
    a = (mode_r == MODE_READ) ? {1'b0, age_r} : idx_r;
    s_slot = slot(7'(shead_r[ch]), 7'(sfill_r[ch]), a, 7'(SAMPLE_DEPTH));
    m_slot = slot(7'(mhead_r[ch]), 7'(mfill_r[ch]), a, 7'(MINUTE_DEPTH));
    h_slot = slot(7'(hhead_r[ch]), 7'(hfill_r[ch]), a, 7'(HOUR_DEPTH));
  end

  assign s_ra = SA_W'(ch * SAMPLE_DEPTH + 32'(s_slot));
  assign m_ra = MA_W'(ch * MINUTE_DEPTH + 32'(m_slot));
  assign h_ra = HA_W'(ch * HOUR_DEPTH + 32'(h_slot));
  assign s_wa = SA_W'(ch * SAMPLE_DEPTH + 32'(shead_r[ch]));
  assign m_wa = MA_W'(ch * MINUTE_DEPTH + 32'(mhead_r[ch]));
  assign h_wa = HA_W'(ch * HOUR_DEPTH + 32'(hhead_r[ch]));
  assign s_wd = samp_r;
  assign m_wd = div_q[SAMPLE_WIDTH-1:0];
  assign h_wd = div_q[SAMPLE_WIDTH-1:0];
  assign s_we = (state_r == S_SWR);
  assign m_we = (state_r == S_MWR);
  assign h_we = (state_r == S_HWR);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign div_go    = (state_r == S_DIVGO);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    accum_nxt = accum_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_RDADDR;
      end
      S_RDADDR: begin
        // dispatch; read address for age is presented this cycle
        if (!ch_ok) state_nxt = S_OUT;
        else if (mode_r == MODE_READ) state_nxt = S_RDWAIT;
        else state_nxt = S_SWR;
      end
      S_RDWAIT: state_nxt = S_RDOUT;
      S_RDOUT:  state_nxt = S_OUT;
      S_SWR: begin
        idx_nxt   = '0;
        sum_nxt   = '0;
        accum_nxt = 1'b0;
        state_nxt = (stick_inc >= spm_eff) ? S_MSUM : S_OUT;
      end
      S_MSUM, S_HSUM: begin
        // one read issued per cycle, its data accumulated in the next cycle
        if (accum_r) begin
          sum_nxt = sum_r + SUM_W'($signed(state_r == S_MSUM ? s_rd : m_rd));
        end
        if (idx_r < cnt_r) begin
          idx_nxt   = idx_r + 1'b1;
          accum_nxt = 1'b1;
        end else begin
          accum_nxt = 1'b0;
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: state_nxt = (accum_r) ? S_DIVGO : ((res_r.minute_pushed) ? S_HDIV : S_MDIV);
      S_MDIV: if (!div_busy) state_nxt = S_MWR;
      S_MWR: begin
        idx_nxt   = '0;
        sum_nxt   = '0;
        accum_nxt = 1'b0;
        state_nxt = (mtick_inc >= mph_eff) ? S_HSUM : S_OUT;
      end
      S_HDIV: if (!div_busy) state_nxt = S_HWR;
      S_HWR:  state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      spm_r   <= 6'd60;
      mph_r   <= 6'd60;
      accum_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sfill_r[i] <= '0; mfill_r[i] <= '0; hfill_r[i] <= '0;
        shead_r[i] <= '0; mhead_r[i] <= '0; hhead_r[i] <= '0;
        stick_r[i] <= '0; mtick_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      accum_r <= accum_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_SPM) spm_r <= cfg_data;
        else mph_r <= cfg_data;
      end
      // sample push: head, fill, tick
      if (state_r == S_SWR) begin
        shead_r[ch] <= (32'(shead_r[ch]) == SAMPLE_DEPTH - 1) ? '0 : shead_r[ch] + 1'b1;
        if (32'(sfill_r[ch]) < SAMPLE_DEPTH) sfill_r[ch] <= sfill_r[ch] + 1'b1;
        stick_r[ch] <= (stick_inc >= spm_eff) ? 6'd0 : stick_inc;
      end
      if (state_r == S_MWR) begin
        mhead_r[ch] <= (32'(mhead_r[ch]) == MINUTE_DEPTH - 1) ? '0 : mhead_r[ch] + 1'b1;
        if (32'(mfill_r[ch]) < MINUTE_DEPTH) mfill_r[ch] <= mfill_r[ch] + 1'b1;
        mtick_r[ch] <= (mtick_inc >= mph_eff) ? 6'd0 : mtick_inc;
      end
      if (state_r == S_HWR) begin
        hhead_r[ch] <= (32'(hhead_r[ch]) == HOUR_DEPTH - 1) ? '0 : hhead_r[ch] + 1'b1;
        if (32'(hfill_r[ch]) < HOUR_DEPTH) hfill_r[ch] <= hfill_r[ch] + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    if (state_r == S_IDLE && in_valid) begin
      mode_r <= in_mode;
      chan_r <= in_channel;
      samp_r <= in_sample;
      lvl_r  <= in_level;
      age_r  <= in_age_index;
      res_r  <= '0;
    end
    // window counts are taken after the push
    if (state_r == S_SWR) cnt_r <= (32'(sf_new) < SAMPLE_DEPTH) ? sf_new + 1'b1 : sf_new;
    if (state_r == S_MWR) cnt_r <= (32'(mf_new) < MINUTE_DEPTH) ? mf_new + 1'b1 : mf_new;
    if (state_r == S_RDOUT) begin
      unique case (lvl_r)
        LVL_SAMPLE: begin
          res_r.level_fill <= 6'(sfill_r[ch]);
          res_r.read_hit   <= ({1'b0, age_r} < 7'(sfill_r[ch]));
          res_r.read_value <= ({1'b0, age_r} < 7'(sfill_r[ch])) ? s_rd : '0;
        end
        LVL_MINUTE: begin
          res_r.level_fill <= 6'(mfill_r[ch]);
          res_r.read_hit   <= ({1'b0, age_r} < 7'(mfill_r[ch]));
          res_r.read_value <= ({1'b0, age_r} < 7'(mfill_r[ch])) ? m_rd : '0;
        end
        LVL_HOUR: begin
          res_r.level_fill <= 6'(hfill_r[ch]);
          res_r.read_hit   <= ({1'b0, age_r} < 7'(hfill_r[ch]));
          res_r.read_value <= ({1'b0, age_r} < 7'(hfill_r[ch])) ? h_rd : '0;
        end
        default: ;
      endcase
    end
    if (state_r == S_MWR) begin
      res_r.minute_pushed <= 1'b1;
      res_r.minute_mean   <= div_q[SAMPLE_WIDTH-1:0];
    end
    if (state_r == S_HWR) begin
      res_r.hour_pushed <= 1'b1;
      res_r.hour_mean   <= div_q[SAMPLE_WIDTH-1:0];
    end
  end

  assign out_minute_pushed = res_r.minute_pushed;
  assign out_minute_mean   = res_r.minute_mean;
  assign out_hour_pushed   = res_r.hour_pushed;
  assign out_hour_mean     = res_r.hour_mean;
  assign out_read_value    = res_r.read_value;
  assign out_read_hit      = res_r.read_hit;
  assign out_level_fill    = res_r.level_fill;
endmodule

FILE: src/mrwa_checker.sv
// Port-level checker for the averager core, with its bind.
module mrwa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_read_hit,
  input logic [5:0]  out_level_fill,
  input logic        out_minute_pushed,
  input logic        out_hour_pushed
);
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hit_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_hit) |-> (out_level_fill != 6'd0))
    else $error("hit on empty window");
  a_hour_minute: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hour_pushed) |-> out_minute_pushed)
    else $error("hour push without minute push");
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready) else $error("not ready after transfer");
  a_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_minute_pushed) |-> !out_read_hit)
    else $error("add and read results mixed");
endmodule

bind multi_rate_window_averager_core mrwa_checker u_mrwa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_read_hit(out_read_hit),
  .out_level_fill(out_level_fill), .out_minute_pushed(out_minute_pushed),
  .out_hour_pushed(out_hour_pushed));

FILE: sim/multi_rate_window_averager_core_tb.sv
// Testbench for the multi-rate window averager core: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module multi_rate_window_averager_core_tb;
  import mrwa_pkg::*;

  localparam int NCH = 16;
  localparam int SDEP = 60;
  localparam int MDEP = 60;
  localparam int HDEP = 24;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic             mode;
    logic [3:0]       channel;
    logic [FieldW-1:0] sample;
    logic [1:0]       level;
    logic [5:0]       age_index;
  } item_t;

  // Directed row: item plus optional typed-in expectation
  typedef struct {
    item_t   item;
    bit      has_exp;
    result_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [5:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [3:0] in_channel = '0;
  logic signed [FieldW-1:0] in_sample = '0;
  logic [1:0] in_level = '0;
  logic [5:0] in_age_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_minute_pushed;
  logic signed [FieldW-1:0] out_minute_mean;
  logic out_hour_pushed;
  logic signed [FieldW-1:0] out_hour_mean;
  logic signed [FieldW-1:0] out_read_value;
  logic out_read_hit;
  logic [5:0] out_level_fill;

  multi_rate_window_averager_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_channel(in_channel),
    .in_sample(in_sample), .in_level(in_level), .in_age_index(in_age_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_minute_pushed(out_minute_pushed), .out_minute_mean(out_minute_mean),
    .out_hour_pushed(out_hour_pushed), .out_hour_mean(out_hour_mean),
    .out_read_value(out_read_value), .out_read_hit(out_read_hit),
    .out_level_fill(out_level_fill)
  );

  always #5 clk = ~clk;

  // Shadow state of the averager
  logic [5:0] spm_reg, mph_reg;
  longint smp_win [NCH][SDEP];
  longint min_win [NCH][MDEP];
  longint hr_win [NCH][HDEP];
  int s_fill [NCH], m_fill [NCH], h_fill [NCH];
  int s_head [NCH], m_head [NCH], h_head [NCH];
  int sec_tick [NCH], min_tick [NCH];

  result_t pending_results[$];
  bit      pending_checked[$];
  int mismatches = 0;
  int results_seen = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;
  int minute_pushes = 0;
  int hour_pushes = 0;
  int read_hits = 0;

  // Window mean, truncating toward zero (SV signed division truncates)
  function automatic longint window_mean(ref longint win [], input int fill, input int head,
                                         input int depth);
    longint sum;
    sum = 0;
    if (fill == 0) return 0;
    for (int i = 0; i < fill; i++) sum += win[(head + depth - fill + i) % depth];
    return sum / longint'(fill);
  endfunction

  function automatic result_t average_item(item_t it);
    result_t r;
    int ch, spm, mph, fill, head, depth;
    longint v, mm, hm;
    longint tmp [];
    r = '0;
    ch = it.channel;
    if (it.mode == MODE_ADD) begin
      spm = (spm_reg == 0) ? 1 : spm_reg;
      mph = (mph_reg == 0) ? 1 : mph_reg;
      v = longint'(signed'(it.sample));
      smp_win[ch][s_head[ch] % SDEP] = v;
      s_head[ch] = (s_head[ch] % SDEP + 1) % SDEP;
      if (s_fill[ch] < SDEP) s_fill[ch]++;
      sec_tick[ch] = (sec_tick[ch] + 1) & 63;
      if (sec_tick[ch] >= spm) begin
        tmp = new[SDEP];
        foreach (tmp[i]) tmp[i] = smp_win[ch][i];
        mm = window_mean(tmp, s_fill[ch], s_head[ch], SDEP);
        sec_tick[ch] = 0;
        min_win[ch][m_head[ch] % MDEP] = mm;
        m_head[ch] = (m_head[ch] % MDEP + 1) % MDEP;
        if (m_fill[ch] < MDEP) m_fill[ch]++;
        r.minute_pushed = 1'b1;
        r.minute_mean = mm[FieldW-1:0];
        min_tick[ch] = (min_tick[ch] + 1) & 63;
        if (min_tick[ch] >= mph) begin
          tmp = new[MDEP];
          foreach (tmp[i]) tmp[i] = min_win[ch][i];
          hm = window_mean(tmp, m_fill[ch], m_head[ch], MDEP);
          min_tick[ch] = 0;
          hr_win[ch][h_head[ch] % HDEP] = hm;
          h_head[ch] = (h_head[ch] % HDEP + 1) % HDEP;
          if (h_fill[ch] < HDEP) h_fill[ch]++;
          r.hour_pushed = 1'b1;
          r.hour_mean = hm[FieldW-1:0];
        end
      end
      return r;
    end
    case (it.level)
      LVL_SAMPLE: begin fill = s_fill[ch]; head = s_head[ch]; depth = SDEP; end
      LVL_MINUTE: begin fill = m_fill[ch]; head = m_head[ch]; depth = MDEP; end
      LVL_HOUR:   begin fill = h_fill[ch]; head = h_head[ch]; depth = HDEP; end
      default: return r;
    endcase
    r.level_fill = fill[5:0];
    if (it.age_index < fill) begin
      head = (head + depth - fill + it.age_index) % depth;
      case (it.level)
        LVL_SAMPLE: v = smp_win[ch][head];
        LVL_MINUTE: v = min_win[ch][head];
        default:    v = hr_win[ch][head];
      endcase
      r.read_value = v[FieldW-1:0];
      r.read_hit = 1'b1;
    end
    return r;
  endfunction

  task automatic write_register(input logic idx, input logic [5:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SPM) spm_reg = val; else mph_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one item; optional typed expectation is checked too
  task automatic send_item(input item_t it, input bit has_exp, input result_t exp);
    result_t pred;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_channel <= it.channel;
    in_sample <= it.sample;
    in_level <= it.level;
    in_age_index <= it.age_index;
    do @(posedge clk); while (!in_ready);
    pred = average_item(it);
    if (has_exp && pred != exp) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees with predictor: %p vs %p", exp, pred);
    end
    pending_results.push_back(pred);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_pending();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic item_t add_item(int ch, logic [FieldW-1:0] s);
    item_t it;
    it = '{MODE_ADD, ch[3:0], s, 2'($urandom_range(3)), 6'($urandom_range(63))};
    return it;
  endfunction

  function automatic item_t read_item(int ch, logic [1:0] lv, int age);
    item_t it;
    it = '{MODE_READ, ch[3:0], FieldW'($urandom), lv, age[5:0]};
    return it;
  endfunction

  function automatic result_t miss_result(int fill);
    result_t r;
    r = '0;
    r.level_fill = fill[5:0];
    return r;
  endfunction

  // Receiver: random stall, long hold on request, compare each transfer
  always @(negedge clk) begin
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    result_t got, exp;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_minute_pushed, out_minute_mean, out_hour_pushed, out_hour_mean,
              out_read_value, out_read_hit, out_level_fill};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        exp = pending_results.pop_front();
        if (exp.minute_pushed) minute_pushes++;
        if (exp.hour_pushed) hour_pushes++;
        if (exp.read_hit) read_hits++;
        if (got != exp) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", exp, got);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer, not counted while the receiver is held
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (!recv_hold)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic random_phase(input int n);
    int ch, r;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(3);
      r = $urandom_range(99);
      if (r < 70) begin
        // mostly random values, sometimes extremes
        if ($urandom_range(9) == 0)
          send_item(add_item(ch, $urandom_range(1) ? 24'h7fffff : 24'h800000), 0, '0);
        else
          send_item(add_item(ch, FieldW'($urandom)), 0, '0);
      end else begin
        send_item(read_item(ch, 2'($urandom_range(3)),
                  $urandom_range(1) ? $urandom_range(63) : $urandom_range(5)), 0, '0);
      end
    end
  endtask

  initial begin
    row_t rows[$];
    row_t rw;
    spm_reg = 6'd60;
    mph_reg = 6'd60;
    for (int c = 0; c < NCH; c++) begin
      s_fill[c] = 0; m_fill[c] = 0; h_fill[c] = 0;
      s_head[c] = 0; m_head[c] = 0; h_head[c] = 0;
      sec_tick[c] = 0; min_tick[c] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at reset periods: empty reads, then extremes
    rw = '{read_item(0, LVL_SAMPLE, 0), 1, miss_result(0)}; rows.push_back(rw);
    rw = '{read_item(15, LVL_HOUR, 63), 1, miss_result(0)}; rows.push_back(rw);
    rw = '{read_item(3, 2'd3, 0), 1, miss_result(0)}; rows.push_back(rw);
    rw = '{add_item(15, 24'h7fffff), 1, '0}; rows.push_back(rw);
    rw = '{add_item(15, 24'h800000), 1, '0}; rows.push_back(rw);
    rw = '{read_item(15, LVL_SAMPLE, 1), 0, '0}; rows.push_back(rw);
    rw = '{read_item(15, LVL_SAMPLE, 2), 1, miss_result(2)}; rows.push_back(rw);
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp);
    drain_pending();

    // Period 1 everywhere: every add pushes minute and hour
    write_register(CFG_SPM, 6'd1);
    write_register(CFG_MPH, 6'd1);
    rows.delete();
    rw = '{add_item(1, 24'h7fffff), 0, '0}; rows.push_back(rw);
    rw = '{add_item(1, 24'h800000), 0, '0}; rows.push_back(rw);
    rw = '{add_item(1, 24'h000001), 0, '0}; rows.push_back(rw);
    rw = '{add_item(1, 24'hffffff), 0, '0}; rows.push_back(rw);
    rw = '{read_item(1, LVL_MINUTE, 0), 0, '0}; rows.push_back(rw);
    rw = '{read_item(1, LVL_HOUR, 3), 0, '0}; rows.push_back(rw);
    rw = '{read_item(1, LVL_HOUR, 4), 1, miss_result(4)}; rows.push_back(rw);
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp);
    drain_pending();

    // Period 0 acts as 1; then lower below a running tick
    write_register(CFG_SPM, 6'd0);
    write_register(CFG_MPH, 6'd0);
    send_item(add_item(2, 24'h123456), 0, '0);
    drain_pending();
    write_register(CFG_SPM, 6'd63);
    write_register(CFG_MPH, 6'd2);
    for (int i = 0; i < 5; i++) send_item(add_item(2, FieldW'($urandom)), 0, '0);
    drain_pending();
    write_register(CFG_SPM, 6'd2);
    send_item(add_item(2, 24'h000100), 0, '0);
    drain_pending();

    // Random phases at several settings; fills the sample window past its depth
    write_register(CFG_SPM, 6'd3);
    write_register(CFG_MPH, 6'd4);
    sender_idle_pct = 14; recv_idle_pct = 74;
    random_phase(170);
    drain_pending();

    // Pressure: receiver holds off while the sender keeps offering
    write_register(CFG_SPM, 6'd2);
    write_register(CFG_MPH, 6'd60);
    sender_idle_pct = 74; recv_idle_pct = 14;
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(negedge clk);
        recv_hold = 1'b0;
      end
      random_phase(170);
    join
    drain_pending();

    write_register(CFG_SPM, 6'd1);
    write_register(CFG_MPH, 6'd2);
    sender_idle_pct = 0; recv_idle_pct = 0;
    random_phase(170);
    drain_pending();

    $display("covered adds and reads on all levels, %0d minute and %0d hour pushes,",
             minute_pushes, hour_pushes);
    $display("%0d read hits, %0d results checked, %0d mismatches", read_hits, results_seen,
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
